### src/kst_pkg.sv
`timescale 1ns / 1ps

package kst_pkg;

  // Build defaults
  localparam int unsigned DEF_MAX_K   = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Field widths
  localparam int unsigned LETTER_W   = 8;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned SID_W      = 32;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned KCFG_W     = 4;
  localparam int unsigned KIDX_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Register reset values
  localparam logic [KCFG_W-1:0] KMER_LENGTH_RST  = 4'd8;
  localparam logic [SLOT_W-1:0] MAX_PER_KMER_RST = 10'd500;

  // Character codes
  localparam logic [LETTER_W-1:0] CHAR_A = 8'h41;
  localparam logic [LETTER_W-1:0] CHAR_C = 8'h43;
  localparam logic [LETTER_W-1:0] CHAR_G = 8'h47;
  localparam logic [LETTER_W-1:0] CHAR_T = 8'h54;
  localparam logic [LETTER_W-1:0] CHAR_Z = 8'h5A;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KMER_LENGTH  = 2'd0,
    CFG_MAX_PER_KMER = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic             valid;
    logic [1:0]       code;
  } kst_base_t;

  // Classified letter travelling from front to back (index travels alongside)
  typedef struct packed {
    logic             ready;
    logic             bad;
    logic [POS_W-1:0] spos;
    logic [SID_W-1:0] sid;
  } kst_mid_t;

  typedef struct packed {
    logic              window_ready;
    logic              stored;
    logic [KIDX_W-1:0] kmer_index;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  start_position;
    logic [SID_W-1:0]  location_seq_id;
    logic              bad_letter;
  } kst_result_t;

  function automatic kst_base_t kst_decode(input logic [LETTER_W-1:0] c);
    kst_base_t b;
    b.valid = 1'b1;
    b.code  = 2'd0;
    case (c)
      CHAR_A:  b.code = 2'd0;
      CHAR_C:  b.code = 2'd1;
      CHAR_G:  b.code = 2'd2;
      CHAR_T:  b.code = 2'd3;
      default: b.valid = 1'b0;
    endcase
    return b;
  endfunction

endpackage

### src/kst_fifo.sv
`timescale 1ns / 1ps

module kst_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = kst_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             empty_o
);
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = store_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

### src/kst_front.sv
`timescale 1ns / 1ps

module kst_front #(
  parameter int unsigned MAX_K = kst_pkg::DEF_MAX_K
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [kst_pkg::LETTER_W-1:0]     letter_i,
  input  logic                             seq_start_i,
  input  logic [kst_pkg::SID_W-1:0]        sequence_id_i,
  input  logic [$clog2(MAX_K + 1)-1:0]     k_i,
  input  logic                             kclr_i,
  output kst_pkg::kst_mid_t                mid_o,
  output logic [2*MAX_K-1:0]               idx_o
);
  import kst_pkg::*;

  localparam int unsigned IDX_W = 2 * MAX_K;
  localparam int unsigned K_W   = $clog2(MAX_K + 1);

  kst_base_t        base;
  logic [IDX_W-1:0] roll_q, roll_d, roll_base, roll_mask, code_sh;
  logic [K_W-1:0]   run_q, run_d, run_base;
  logic [POS_W-1:0] pos_q, pos_cur;
  logic             ready;

  always_comb begin
    base      = kst_decode(letter_i);
    // A new sequence clears the window and position before this letter
    roll_base = seq_start_i ? '0 : roll_q;
    run_base  = seq_start_i ? '0 : run_q;
    pos_cur   = seq_start_i ? '0 : pos_q;
    roll_mask = ~({IDX_W{1'b1}} << {k_i, 1'b0});
    code_sh   = IDX_W'(base.code) << {k_i - K_W'(1), 1'b0};
    if (base.valid) begin
      roll_d = ((roll_base >> 2) | code_sh) & roll_mask;
      run_d  = (run_base < k_i) ? run_base + K_W'(1) : run_base;
    end else begin
      roll_d = '0;
      run_d  = '0;
    end
    ready = (run_d >= k_i);

    mid_o.ready = ready;
    mid_o.bad   = (letter_i < CHAR_A) || (letter_i > CHAR_Z);
    mid_o.spos  = ready ? (pos_cur - POS_W'(k_i) + POS_W'(1)) : '0;
    mid_o.sid   = sequence_id_i;
    idx_o       = ready ? roll_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q <= '0;
      run_q  <= '0;
      pos_q  <= '0;
    end else if (kclr_i) begin
      roll_q <= '0;
      run_q  <= '0;
    end else if (accept_i) begin
      roll_q <= roll_d;
      run_q  <= run_d;
      pos_q  <= pos_cur + POS_W'(1);
    end
  end

endmodule

### src/kst_back.sv
`timescale 1ns / 1ps

module kst_back #(
  parameter int unsigned MAX_K = kst_pkg::DEF_MAX_K
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  kst_pkg::kst_mid_t             mid_i,
  input  logic [2*MAX_K-1:0]            idx_i,
  input  logic [kst_pkg::SLOT_W-1:0]    max_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output kst_pkg::kst_result_t          res_o,
  output logic                          busy_o
);
  import kst_pkg::*;

  localparam int unsigned     IDX_W = 2 * MAX_K;
  localparam longint unsigned DEPTH = 64'd1 << IDX_W;

  logic [SLOT_W-1:0] count_mem [DEPTH];

  logic              clr_busy_q;
  logic [IDX_W-1:0]  clr_addr_q;
  logic              s1_valid_q;
  kst_mid_t          s1_mid_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic [SLOT_W-1:0] rdata_q;
  logic              byp_valid_q;
  logic [IDX_W-1:0]  byp_addr_q;
  logic [SLOT_W-1:0] byp_data_q;

  logic              s1_ready, s1_load, s1_fire, admit, wr_item;
  logic [SLOT_W-1:0] cnt;

  assign busy_o      = clr_busy_q;
  assign s1_ready    = !s1_valid_q || res_ready_i;
  assign in_ready_o  = s1_ready && !clr_busy_q;
  assign s1_load     = in_valid_i && in_ready_o;
  assign s1_fire     = s1_valid_q && res_ready_i;
  assign res_valid_o = s1_valid_q;

  // Forward the write made at the edge this entry was read
  assign cnt     = (byp_valid_q && (byp_addr_q == s1_idx_q)) ? byp_data_q : rdata_q;
  assign admit   = s1_mid_q.ready && (cnt < max_i);
  assign wr_item = s1_fire && admit;

  always_comb begin
    res_o.window_ready    = s1_mid_q.ready;
    res_o.stored          = admit;
    res_o.kmer_index      = KIDX_W'(s1_idx_q);
    res_o.slot            = s1_mid_q.ready ? cnt : '0;
    res_o.start_position  = s1_mid_q.spos;
    res_o.location_seq_id = s1_mid_q.sid;
    res_o.bad_letter      = s1_mid_q.bad;
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      count_mem[clr_addr_q] <= '0;
    end else if (wr_item) begin
      count_mem[s1_idx_q] <= cnt + SLOT_W'(1);
    end
    if (s1_load) begin
      rdata_q <= count_mem[idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_mid_q <= mid_i;
      s1_idx_q <= idx_i;
    end
    if (wr_item) begin
      byp_addr_q <= s1_idx_q;
      byp_data_q <= cnt + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      byp_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + IDX_W'(1);
        if (clr_addr_q == {IDX_W{1'b1}}) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (wr_item) begin
        byp_valid_q <= 1'b1;
      end
    end
  end

endmodule

### src/kmer_seed_table_insert_top.sv
// An accepted letter passes the front queue, back stage and result queue (empty low).
// Throughput: one letter per cycle while pop keeps up and no clear runs; the count
//   table does one read and one write per cycle, with the pending write forwarded so
//   repeated k-mers keep the full rate. Reset: asynchronous, active low.
// After reset the count table is cleared one entry a cycle, all 4^MAX_K entries
//   (65536 at MAX_K = 8) with full high; configuration writes are taken meanwhile.
`timescale 1ns / 1ps

module kmer_seed_table_insert_top #(
  parameter int unsigned MAX_K = kst_pkg::DEF_MAX_K
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Letter queue side
  input  logic                              push,
  output logic                              full,
  input  logic [kst_pkg::LETTER_W-1:0]      letter_i,
  input  logic                              seq_start_i,
  input  logic [kst_pkg::SID_W-1:0]         sequence_id_i,
  // Result queue side
  output logic                              empty,
  input  logic                              pop,
  output logic                              window_ready_o,
  output logic                              stored_o,
  output logic [kst_pkg::KIDX_W-1:0]        kmer_index_o,
  output logic [kst_pkg::SLOT_W-1:0]        slot_o,
  output logic [kst_pkg::POS_W-1:0]         start_position_o,
  output logic [kst_pkg::SID_W-1:0]         location_seq_id_o,
  output logic                              bad_letter_o,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [kst_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [kst_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import kst_pkg::*;

  localparam int unsigned IDX_W = 2 * MAX_K;
  localparam int unsigned K_W   = $clog2(MAX_K + 1);
  localparam int unsigned MID_W = IDX_W + $bits(kst_mid_t);
  localparam int unsigned RES_W = $bits(kst_result_t);

  // Configuration registers
  logic [KCFG_W-1:0] kcfg_q;
  logic [SLOT_W-1:0] max_q;
  logic [K_W-1:0]    k_eff;
  logic              kclr;

  // Front to back queue
  kst_mid_t          front_mid;
  logic [IDX_W-1:0]  front_idx;
  logic [MID_W-1:0]  mq_dout;
  logic              mq_full, mq_empty, mq_pop;
  kst_mid_t          mq_mid;
  logic [IDX_W-1:0]  mq_idx;

  // Back and result queue
  logic              back_ready, back_busy, res_valid, of_full;
  kst_result_t       back_res, out_res;
  logic [RES_W-1:0]  of_dout;

  logic              accept;

  // Hold the letter queue closed while the table is being cleared
  assign full   = mq_full || back_busy;
  assign accept = push && !full;

  // Clamp the window length: zero acts as one, above the build maximum as the maximum
  always_comb begin
    if (kcfg_q == '0) begin
      k_eff = K_W'(1);
    end else if (32'(kcfg_q) > MAX_K) begin
      k_eff = K_W'(MAX_K);
    end else begin
      k_eff = K_W'(kcfg_q);
    end
  end

  assign kclr = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == CFG_KMER_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcfg_q <= KMER_LENGTH_RST;
      max_q  <= MAX_PER_KMER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_KMER_LENGTH:  kcfg_q <= cfg_data_i[KCFG_W-1:0];
        CFG_MAX_PER_KMER: max_q  <= cfg_data_i[SLOT_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Front: decode the letter, roll the window, stamp the position
  kst_front #(
    .MAX_K (MAX_K)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .letter_i      (letter_i),
    .seq_start_i   (seq_start_i),
    .sequence_id_i (sequence_id_i),
    .k_i           (k_eff),
    .kclr_i        (kclr),
    .mid_o         (front_mid),
    .idx_o         (front_idx)
  );

  // Short queue decoupling the front from the table update
  kst_fifo #(
    .WIDTH (MID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .din_i   ({front_idx, front_mid}),
    .full_o  (mq_full),
    .pop_i   (mq_pop),
    .dout_o  (mq_dout),
    .empty_o (mq_empty)
  );

  assign mq_idx = mq_dout[MID_W-1 -: IDX_W];
  assign mq_mid = kst_mid_t'(mq_dout[$bits(kst_mid_t)-1:0]);
  assign mq_pop = back_ready && !mq_empty;

  // Back: count table read-modify-write under the cap
  kst_back #(
    .MAX_K (MAX_K)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!mq_empty),
    .in_ready_o  (back_ready),
    .mid_i       (mq_mid),
    .idx_i       (mq_idx),
    .max_i       (max_q),
    .res_valid_o (res_valid),
    .res_ready_i (!of_full),
    .res_o       (back_res),
    .busy_o      (back_busy)
  );

  // Result queue: finished transactions wait here, stalling the back only once it fills
  kst_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .din_i   (back_res),
    .full_o  (of_full),
    .pop_i   (pop),
    .dout_o  (of_dout),
    .empty_o (empty)
  );

  assign out_res           = kst_result_t'(of_dout);
  assign window_ready_o    = out_res.window_ready;
  assign stored_o          = out_res.stored;
  assign kmer_index_o      = out_res.kmer_index;
  assign slot_o            = out_res.slot;
  assign start_position_o  = out_res.start_position;
  assign location_seq_id_o = out_res.location_seq_id;
  assign bad_letter_o      = out_res.bad_letter;

  // The clearing pass must finish with nothing in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(back_busy) |-> (mq_empty && empty))
    else $error("items in flight while the count table was being cleared");

  // An accepted letter must land in the front queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !mq_empty)
    else $error("accepted letter missing from the front queue");

  // A store is only reported for a complete window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && stored_o) |-> window_ready_o)
    else $error("store reported without a ready window");

  // Without a window, index and slot read as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !window_ready_o) |-> ((slot_o == '0) && (kmer_index_o == '0)))
    else $error("non-zero index or slot on a result without a window");

endmodule

### dv/kmer_seed_table_insert_top_tb.sv
`timescale 1ns / 1ps

module kmer_seed_table_insert_top_tb;
  import kst_pkg::*;

  localparam int unsigned TB_MAX_K    = DEF_MAX_K;
  localparam int unsigned CLK_HALF    = 6;
  localparam int unsigned RESET_LEN   = 11;
  // Result goes through the front queue, back stage and result queue; add a little margin.
  localparam int unsigned SETTLE_LEN  = 4;
  // The table clear after reset holds full high over all 4^MAX_K entries, so the
  // watchdog has to sit well above that.
  localparam int unsigned TABLE_DEPTH = 1 << (2 * TB_MAX_K);
  localparam int unsigned WATCHDOG_LIMIT = 4 * TABLE_DEPTH + 1000;
  localparam int unsigned MAX_REPORTS  = 10;

  // Register indexes past the end of the register list; writes must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum logic [1:0] {
    BASE_A,
    BASE_C,
    BASE_G,
    BASE_T
  } base_e;

  typedef enum int {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_e;

  // One row of the directed script: the letter transaction and, where it can
  // be read straight off, the result it must produce.
  typedef struct {
    logic [LETTER_W-1:0] ch;
    logic                start;
    logic [SID_W-1:0]    sid;
    bit                  typed;
    kst_result_t         res;
  } letter_row_t;

  // DUT ports
  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [LETTER_W-1:0]   letter_i;
  logic                  seq_start_i;
  logic [SID_W-1:0]      sequence_id_i;
  logic                  empty;
  logic                  pop;
  logic                  window_ready_o;
  logic                  stored_o;
  logic [KIDX_W-1:0]     kmer_index_o;
  logic [SLOT_W-1:0]     slot_o;
  logic [POS_W-1:0]      start_position_o;
  logic [SID_W-1:0]      location_seq_id_o;
  logic                  bad_letter_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Shadow of the block: registers, rolling window and the count table
  logic [KCFG_W-1:0]     kmer_len_cfg;
  logic [SLOT_W-1:0]     loc_cap;
  logic [SLOT_W-1:0]     hit_count [TABLE_DEPTH];
  logic [KIDX_W-1:0]     roll_idx;
  logic [KCFG_W:0]       run_len;
  logic [POS_W-1:0]      next_pos;

  kst_result_t           awaited_inserts [$];
  letter_row_t           script [$];

  int unsigned           send_idle_pct;
  int unsigned           recv_stall_pct;
  logic [SID_W-1:0]      seq_tag;
  int unsigned           letters_sent;
  int unsigned           inserts_checked;
  int unsigned           stored_total;
  int unsigned           capped_total;
  int unsigned           bad_total;
  int unsigned           settings_run;
  int unsigned           mismatches;
  int unsigned           stall_cycles;
  kst_result_t           got_insert;
  kst_result_t           want_insert;

  logic [LETTER_W-1:0]   base_chars [4];

  kmer_seed_table_insert_top #(
    .MAX_K(TB_MAX_K)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .letter_i         (letter_i),
    .seq_start_i      (seq_start_i),
    .sequence_id_i    (sequence_id_i),
    .empty            (empty),
    .pop              (pop),
    .window_ready_o   (window_ready_o),
    .stored_o         (stored_o),
    .kmer_index_o     (kmer_index_o),
    .slot_o           (slot_o),
    .start_position_o (start_position_o),
    .location_seq_id_o(location_seq_id_o),
    .bad_letter_o     (bad_letter_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Work out the result of one letter and advance the shadow state.
  function automatic kst_result_t predict_insert(input logic [LETTER_W-1:0] ch,
                                                 input logic start,
                                                 input logic [SID_W-1:0] sid);
    kst_result_t      r;
    int unsigned      k;
    logic [31:0]      mask;
    logic [31:0]      widened;
    base_e            code;
    bit               is_base;
    logic [POS_W-1:0] pos;

    // Zero behaves as one, anything beyond the built maximum as the maximum.
    k = (kmer_len_cfg == 0) ? 1 :
        (kmer_len_cfg > TB_MAX_K) ? TB_MAX_K : int'(kmer_len_cfg);
    mask = 32'hFFFF_FFFF >> (32 - 2 * k);

    r = '0;
    r.location_seq_id = sid;
    r.bad_letter = (ch < CHAR_A) || (ch > CHAR_Z);

    // A sequence start clears the window and the position before this letter.
    if (start) begin
      roll_idx = '0;
      run_len  = '0;
      next_pos = '0;
    end
    pos = next_pos;

    is_base = 1'b1;
    code    = BASE_A;
    case (ch)
      CHAR_A:  code = BASE_A;
      CHAR_C:  code = BASE_C;
      CHAR_G:  code = BASE_G;
      CHAR_T:  code = BASE_T;
      default: is_base = 1'b0;
    endcase

    // Newest letter enters at the top, the oldest drops off the bottom.
    if (is_base) begin
      widened  = ({16'b0, roll_idx} >> 2) | (32'(code) << (2 * (k - 1)));
      roll_idx = KIDX_W'(widened & mask);
      if (run_len < k) run_len = run_len + 1'b1;
    end else begin
      roll_idx = '0;
      run_len  = '0;
    end

    if (run_len >= k) begin
      r.window_ready   = 1'b1;
      r.kmer_index     = roll_idx;
      r.slot           = hit_count[roll_idx];
      r.start_position = pos - POS_W'(k - 1);
      if (hit_count[roll_idx] < loc_cap) begin
        r.stored = 1'b1;
        hit_count[roll_idx] = hit_count[roll_idx] + 1'b1;
        stored_total++;
      end else begin
        capped_total++;
      end
    end
    if (r.bad_letter) bad_total++;

    next_pos = pos + 1'b1;
    return r;
  endfunction

  function automatic void plan_letter(input logic [LETTER_W-1:0] ch, input logic start,
                                      input logic [SID_W-1:0] sid);
    letter_row_t row;
    row.ch    = ch;
    row.start = start;
    row.sid   = sid;
    row.typed = 1'b0;
    row.res   = '0;
    script.push_back(row);
  endfunction

  function automatic void plan_checked(input logic [LETTER_W-1:0] ch, input logic start,
                                       input logic [SID_W-1:0] sid, input logic ready,
                                       input logic stored, input logic [KIDX_W-1:0] kidx,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [POS_W-1:0] spos, input logic bad);
    letter_row_t row;
    row.ch                  = ch;
    row.start               = start;
    row.sid                 = sid;
    row.typed               = 1'b1;
    row.res.window_ready    = ready;
    row.res.stored          = stored;
    row.res.kmer_index      = kidx;
    row.res.slot            = slot;
    row.res.start_position  = spos;
    row.res.location_seq_id = sid;
    row.res.bad_letter      = bad;
    script.push_back(row);
  endfunction

  // Offer one letter transaction, with random gaps ahead of it, and log the
  // expected result once it is taken.
  task automatic send_letter(input logic [LETTER_W-1:0] ch, input logic start,
                             input logic [SID_W-1:0] sid, input bit typed,
                             input kst_result_t given);
    kst_result_t predicted;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push          = 1'b1;
    letter_i      = ch;
    seq_start_i   = start;
    sequence_id_i = sid;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predicted = predict_insert(ch, start, sid);
    awaited_inserts.push_back(typed ? given : predicted);
    letters_sent++;
  endtask

  // Mostly clean bases, some other capitals, some arbitrary bytes; the odd
  // sequence start lands mid-window.
  task automatic send_random(input int unsigned start_pct);
    logic                start;
    logic [LETTER_W-1:0] ch;
    int unsigned         pick;
    start = ($urandom_range(0, 99) < start_pct);
    if (start) seq_tag = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      ch = base_chars[2'($urandom_range(0, 3))];
    end else if (pick < 92) begin
      ch = LETTER_W'($urandom_range(CHAR_A, CHAR_Z));
    end else begin
      ch = LETTER_W'($urandom_range(0, 255));
    end
    send_letter(ch, start, seq_tag, 1'b0, '0);
  endtask

  // Write only with nothing in flight, then mirror the write in the shadow.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    while (awaited_inserts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_LEN) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    if (idx == CFG_KMER_LENGTH) begin
      // A new length drops the window but keeps the position and the table.
      kmer_len_cfg = data[KCFG_W-1:0];
      roll_idx     = '0;
      run_len      = '0;
    end else if (idx == CFG_MAX_PER_KMER) begin
      loc_cap = data[SLOT_W-1:0];
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_pace(input pace_e pace);
    case (pace)
      PACE_FULL:           begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PACE_SENDER_IDLE:    begin send_idle_pct = 79; recv_stall_pct = 0;  end
      PACE_RECEIVER_STALL: begin send_idle_pct = 0;  recv_stall_pct = 79; end
      default:             begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
  endtask

  // One setting of the registers, one pace, a run of random letters.
  task automatic run_phase(input bit set_k, input logic [KCFG_W-1:0] k,
                           input logic [SLOT_W-1:0] cap, input pace_e pace,
                           input int unsigned count, input int unsigned start_pct);
    // Stuff random junk into the unused upper data bits of the length write.
    if (set_k) write_reg(CFG_KMER_LENGTH, {6'($urandom_range(0, 63)), k});
    write_reg(CFG_MAX_PER_KMER, cap);
    set_pace(pace);
    repeat (count) send_random(start_pct);
    @(negedge clk_i);
    push = 1'b0;
    settings_run++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s mismatch on result %0d: expected 0x%0h, got 0x%0h",
                 $realtime, name, inserts_checked, want, got);
      end
    end
  endtask

  // Result side: hold pop low at random to stall the block.
  always @(negedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare each popped result with the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      got_insert.window_ready    = window_ready_o;
      got_insert.stored          = stored_o;
      got_insert.kmer_index      = kmer_index_o;
      got_insert.slot            = slot_o;
      got_insert.start_position  = start_position_o;
      got_insert.location_seq_id = location_seq_id_o;
      got_insert.bad_letter      = bad_letter_o;
      if (awaited_inserts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result popped with nothing outstanding", $realtime);
        end
      end else begin
        want_insert = awaited_inserts.pop_front();
        check_field("window_ready", 32'(want_insert.window_ready),
                    32'(got_insert.window_ready));
        check_field("stored", 32'(want_insert.stored), 32'(got_insert.stored));
        check_field("kmer_index", 32'(want_insert.kmer_index),
                    32'(got_insert.kmer_index));
        check_field("slot", 32'(want_insert.slot), 32'(got_insert.slot));
        check_field("start_position", 32'(want_insert.start_position),
                    32'(got_insert.start_position));
        check_field("location_seq_id", want_insert.location_seq_id,
                    got_insert.location_seq_id);
        check_field("bad_letter", 32'(want_insert.bad_letter),
                    32'(got_insert.bad_letter));
      end
      inserts_checked++;
    end
  end

  // Watchdog: give up once nothing has moved on either side for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    // Drive every input to a known value from time zero.
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    push          = 1'b0;
    letter_i      = '0;
    seq_start_i   = 1'b0;
    sequence_id_i = '0;
    pop           = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_KMER_LENGTH;
    cfg_data_i    = '0;

    base_chars[BASE_A] = CHAR_A;
    base_chars[BASE_C] = CHAR_C;
    base_chars[BASE_G] = CHAR_G;
    base_chars[BASE_T] = CHAR_T;

    kmer_len_cfg = KMER_LENGTH_RST;
    loc_cap      = MAX_PER_KMER_RST;
    roll_idx     = '0;
    run_len      = '0;
    next_pos     = '0;
    foreach (hit_count[i]) hit_count[i] = '0;

    letters_sent    = 0;
    inserts_checked = 0;
    stored_total    = 0;
    capped_total    = 0;
    bad_total       = 0;
    settings_run    = 0;
    mismatches      = 0;
    seq_tag         = '0;
    set_pace(PACE_FULL);

    repeat (RESET_LEN) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Writes to indexes past the register list must change nothing; these
    // land while the table is still being cleared.
    write_reg(CFG_SPARE_2, 10'h3FF);
    write_reg(CFG_SPARE_3, 10'h001);

    // Directed script at the reset settings: k of 8, cap of 500.
    // Bytes at and just past both ends of the capital range, a capital that is
    // not a base, a lower-case letter.
    plan_checked(CHAR_A, 1'b1, 32'h0000_0000, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    plan_checked(8'h00,  1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0, '0, 1'b1);
    plan_checked(8'hFF,  1'b0, 32'hAAAA_5555, 1'b0, 1'b0, '0, '0, '0, 1'b1);
    plan_checked("@",    1'b0, 32'h5555_AAAA, 1'b0, 1'b0, '0, '0, '0, 1'b1);
    plan_checked("[",    1'b0, 32'h0000_0001, 1'b0, 1'b0, '0, '0, '0, 1'b1);
    plan_checked(CHAR_Z, 1'b0, 32'h8000_0000, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    plan_checked("N",    1'b0, 32'h0000_0002, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    plan_checked("a",    1'b0, 32'h0000_0003, 1'b0, 1'b0, '0, '0, '0, 1'b1);
    // Eight T from a fresh start fill the window with all ones; the ninth
    // hits the same k-mer again at the next slot.
    plan_letter(CHAR_T, 1'b1, 32'h0000_0007);
    repeat (6) plan_letter(CHAR_T, 1'b0, 32'h0000_0007);
    plan_checked(CHAR_T, 1'b0, 32'h0000_0007, 1'b1, 1'b1, 16'hFFFF, 10'd0, 16'd0, 1'b0);
    plan_checked(CHAR_T, 1'b0, 32'h0000_0007, 1'b1, 1'b1, 16'hFFFF, 10'd1, 16'd1, 1'b0);
    plan_letter(CHAR_G, 1'b0, 32'h0000_0007);
    plan_letter(CHAR_C, 1'b0, 32'h0000_0007);
    // A non-base capital breaks the window.
    plan_checked("N", 1'b0, 32'h0000_0007, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    // Restart: same k-mer, third slot, position back to zero.
    plan_letter(CHAR_T, 1'b1, 32'h8000_0001);
    repeat (6) plan_letter(CHAR_T, 1'b0, 32'h8000_0001);
    plan_checked(CHAR_T, 1'b0, 32'h8000_0001, 1'b1, 1'b1, 16'hFFFF, 10'd2, 16'd0, 1'b0);

    foreach (script[i]) begin
      send_letter(script[i].ch, script[i].start, script[i].sid, script[i].typed,
                  script[i].res);
    end
    @(negedge clk_i);
    push = 1'b0;

    // Random phases over the register extremes and every pace. The phase
    // that keeps k checks the window survives a cap write.
    run_phase(1'b1, 4'd1,  10'd1023, PACE_FULL,           70, 3);
    run_phase(1'b1, 4'd0,  10'd2,    PACE_SENDER_IDLE,    60, 3);
    run_phase(1'b0, 4'd0,  10'd5,    PACE_FULL,           30, 3);
    run_phase(1'b1, 4'd15, 10'd0,    PACE_RECEIVER_STALL, 60, 3);
    run_phase(1'b1, 4'd2,  10'd1,    PACE_BOTH,           60, 4);
    run_phase(1'b1, 4'd8,  10'd500,  PACE_SENDER_IDLE,    40, 2);
    run_phase(1'b1, 4'd3,  10'd4,    PACE_BOTH,           50, 3);
    run_phase(1'b1, 4'd5,  10'd3,    PACE_RECEIVER_STALL, 40, 3);

    // Drain, then wait SETTLE_LEN for any stray result to show up.
    while (awaited_inserts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_LEN) @(posedge clk_i);

    $display("Covered %0d letters over %0d register settings and all four paces",
             letters_sent, settings_run);
    $display("  %0d results checked: %0d stored, %0d at the cap, %0d bad bytes, %0d mismatches",
             inserts_checked, stored_total, capped_total, bad_total, mismatches);
    if (mismatches == 0 && awaited_inserts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
